@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VNDL_ASSERT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vndl assertion failed");

// next-cycle implication
`define VNDL_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vndl assertion failed");

`endif

@@ src/vndl_pkg.sv @@
// constants and types for the vertex lighting pipeline
// no dependencies
package vndl_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int IO_FRAC      = 14;
    localparam int NEWTON_STEPS = 5;
    localparam int UNIT_ONE     = 16384;

    localparam int R_W   = 25;
    localparam int A_W   = 24;
    localparam int LEN_W = 48;
    localparam int Y_W   = FRAC_BITS + 2;
    localparam int SH_W  = 6;
    localparam int U_W   = 16;
    localparam int P_W   = A_W + Y_W;

    localparam logic [LEN_W-1:0] NORMAL_FLOOR = LEN_W'(432959);

    localparam int ROT_LAT   = 2;
    localparam int NORM_LAT  = 4 + 3 * NEWTON_STEPS + 2;
    localparam int SHADE_LAT = 4;
    localparam int PIPE_LAT  = ROT_LAT + NORM_LAT + SHADE_LAT;

    typedef enum logic [2:0]
    {
        CFG_ROT_COS,
        CFG_ROT_SIN,
        CFG_AMBIENT,
        CFG_DIFFUSE,
        CFG_LIGHT
    } cfg_idx_t;

    typedef logic signed [R_W-1:0] rcomp_t;
    typedef logic signed [U_W-1:0] ucomp_t;

    typedef struct packed
    {
        logic [2:0][A_W-1:0] mag;
        logic [2:0]          neg;
        logic                zero;
        logic [SH_W-1:0]     ushift;
    } norm_side_t;

endpackage

@@ src/vndl_rotate.sv @@
// y-axis rotation of the normal and expansion of the light vector
// depends on vndl_pkg
module vndl_rotate
    import vndl_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [7:0]  nx,
    input  logic signed [7:0]  ny,
    input  logic signed [7:0]  nz,
    input  logic signed [15:0] rot_cos,
    input  logic signed [15:0] rot_sin,
    input  logic [23:0]        light,
    output rcomp_t             r [3],
    output rcomp_t             l [3]
);

    logic signed [23:0] xc_reg, zs_reg, zc_reg, xs_reg;
    logic signed [7:0]  ny_reg;
    logic [23:0]        light_reg;
    rcomp_t             r_reg [3];
    rcomp_t             l_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg    <= 24'(nx) * 24'(rot_cos);
            zs_reg    <= 24'(nz) * 24'(rot_sin);
            zc_reg    <= 24'(nz) * 24'(rot_cos);
            xs_reg    <= 24'(nx) * 24'(rot_sin);
            ny_reg    <= ny;
            light_reg <= light;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= R_W'(xc_reg) + R_W'(zs_reg);
            r_reg[1] <= R_W'(ny_reg) <<< FRAC_BITS;
            r_reg[2] <= R_W'(zc_reg) - R_W'(xs_reg);
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i] <= R_W'(signed'(light_reg[8*i +: 8])) <<< IO_FRAC;
            end
        end
    end

    assign r = r_reg;
    assign l = l_reg;

endmodule

@@ src/vndl_norm.sv @@
// vector normalization: squared length, leading-one search and
// newton reciprocal square root, one multiply per newton stage; depends on vndl_pkg
module vndl_norm
    import vndl_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  rcomp_t r [3],
    output ucomp_t u [3]
);

    // stage 0: magnitudes and squares
    logic [LEN_W-1:0] sq_reg [3];
    norm_side_t       side0_reg;
    norm_side_t       side0_next;
    logic [LEN_W-1:0] sq_next [3];

    always_comb
    begin
        side0_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            side0_next.neg[i] = r[i][R_W-1];
            side0_next.mag[i] = r[i][R_W-1] ? A_W'(-r[i]) : A_W'(r[i]);
            sq_next[i] = LEN_W'(side0_next.mag[i]) * LEN_W'(side0_next.mag[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            side0_reg <= side0_next;
        end
    end

    // stage 1: squared length
    logic [LEN_W-1:0] len1_reg;
    norm_side_t       side1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len1_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            side1_reg <= side0_reg;
        end
    end

    // stage 2: floor test and even leading-one position
    logic [LEN_W-1:0] len2_reg;
    norm_side_t       side2_reg;
    norm_side_t       side2_next;
    logic [SH_W-1:0]  msb;

    always_comb
    begin
        msb = '0;
        for (int k = 0; k < LEN_W; k++)
        begin
            if (len1_reg[k])
            begin
                msb = SH_W'(k);
            end
        end
        side2_next        = side1_reg;
        side2_next.zero   = (len1_reg <= NORMAL_FLOOR);
        side2_next.ushift = {msb[SH_W-1:1], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len2_reg  <= len1_reg;
            side2_reg <= side2_next;
        end
    end

    // stage 3: mantissa in [1,4) and seed estimate
    logic [Y_W-1:0]   xq_next;
    logic [LEN_W-1:0] len_sh;
    logic [Y_W-1:0]   y_seed [NEWTON_STEPS+1];
    logic [Y_W-1:0]   xq_seed [NEWTON_STEPS+1];
    norm_side_t       side_seed [NEWTON_STEPS+1];

    always_comb
    begin
        if (side2_reg.ushift >= SH_W'(FRAC_BITS))
        begin
            len_sh = len2_reg >> (side2_reg.ushift - SH_W'(FRAC_BITS));
        end
        else
        begin
            len_sh = len2_reg << (SH_W'(FRAC_BITS) - side2_reg.ushift);
        end
        xq_next = len_sh[Y_W-1:0];
    end

    logic [Y_W-1:0] y3_reg, xq3_reg;
    norm_side_t     side3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xq3_reg   <= xq_next;
            y3_reg    <= (Y_W'(1) << FRAC_BITS) - (xq_next >> 3);
            side3_reg <= side2_reg;
        end
    end

    assign y_seed[0]    = y3_reg;
    assign xq_seed[0]   = xq3_reg;
    assign side_seed[0] = side3_reg;

    // newton iterations, three stages each
    for (genvar k = 0; k < NEWTON_STEPS; k++)
    begin : g_newton
        logic [Y_W-1:0]   ya_reg, y2_reg, xqa_reg;
        logic [Y_W-1:0]   yb_reg, t_reg, xqb_reg;
        logic [Y_W-1:0]   yc_reg, xqc_reg;
        norm_side_t       sa_reg, sb_reg, sc_reg;
        logic [2*Y_W-1:0] sq_p, xy_p, yt_p;
        logic [2*Y_W-1:0] xy2;
        logic [2*Y_W-1:0] thr;
        logic [Y_W-1:0]   t_next;

        always_comb
        begin
            sq_p = (2*Y_W)'(y_seed[k]) * (2*Y_W)'(y_seed[k]);
            xy_p = (2*Y_W)'(xqa_reg) * (2*Y_W)'(y2_reg);
            xy2  = xy_p >> FRAC_BITS;
            thr  = (2*Y_W)'(3) << FRAC_BITS;
            t_next = (xy2 >= thr) ? '0 : Y_W'(thr - xy2);
            yt_p = (2*Y_W)'(yb_reg) * (2*Y_W)'(t_reg);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y2_reg  <= Y_W'(sq_p >> FRAC_BITS);
                ya_reg  <= y_seed[k];
                xqa_reg <= xq_seed[k];
                sa_reg  <= side_seed[k];
                t_reg   <= t_next;
                yb_reg  <= ya_reg;
                xqb_reg <= xqa_reg;
                sb_reg  <= sa_reg;
                yc_reg  <= Y_W'(yt_p >> (FRAC_BITS + 1));
                xqc_reg <= xqb_reg;
                sc_reg  <= sb_reg;
            end
        end

        assign y_seed[k+1]    = yc_reg;
        assign xq_seed[k+1]   = xqc_reg;
        assign side_seed[k+1] = sc_reg;
    end

    // scale each magnitude by the reciprocal root
    logic [P_W-1:0] p_reg [3];
    norm_side_t     sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= P_W'(side_seed[NEWTON_STEPS].mag[i])
                            * P_W'(y_seed[NEWTON_STEPS]);
            end
            sp_reg <= side_seed[NEWTON_STEPS];
        end
    end

    // round by the exponent, clamp, restore sign and zero below the floor
    ucomp_t          u_reg [3];
    ucomp_t          u_next [3];
    logic [SH_W-1:0] sh;
    logic [P_W-1:0]  q;
    logic [P_W-1:0]  m;

    always_comb
    begin
        sh = (sp_reg.ushift >> 1) + SH_W'(FRAC_BITS) - SH_W'(IO_FRAC);
        q  = '0;
        m  = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = p_reg[i] >> (sh - SH_W'(1));
            m = (q + P_W'(1)) >> 1;
            if (m > P_W'(UNIT_ONE))
            begin
                m = P_W'(UNIT_ONE);
            end
            if (sp_reg.zero)
            begin
                u_next[i] = '0;
            end
            else if (sp_reg.neg[i])
            begin
                u_next[i] = -U_W'(m);
            end
            else
            begin
                u_next[i] = U_W'(m);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_next;
        end
    end

    assign u = u_reg;

endmodule

@@ src/vndl_shade.sv @@
// diffuse dot product, color accumulate and round, sphere-map coordinates
// depends on vndl_pkg; the last stage is the output register
module vndl_shade
    import vndl_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  ucomp_t      un [3],
    input  ucomp_t      ln [3],
    input  logic [7:0]  alpha_in,
    input  logic [23:0] ambient,
    input  logic [23:0] diffuse,
    output ucomp_t      unit_out [3],
    output logic [7:0]  color [3],
    output logic [7:0]  alpha_out,
    output logic [14:0] tex_u,
    output logic [14:0] tex_v
);

    localparam int DOT_W = 2 * IO_FRAC + 3;
    localparam int ACC_W = 2 * IO_FRAC + 12;

    // stage 1: component products
    logic signed [DOT_W-1:0] pr_reg [3];
    ucomp_t                  u1_reg [3];
    logic [7:0]              a1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= DOT_W'(un[i]) * DOT_W'(ln[i]);
            end
            u1_reg <= un;
            a1_reg <= alpha_in;
        end
    end

    // stage 2: sum, clamp at zero, texture coordinates
    logic signed [DOT_W-1:0] dot_sum;
    logic [DOT_W-2:0]        dot_reg;
    ucomp_t                  u2_reg [3];
    logic [7:0]              a2_reg;
    logic [14:0]             tu2_reg, tv2_reg;
    logic signed [U_W:0]     tu_s, tv_s;

    always_comb
    begin
        dot_sum = pr_reg[0] + pr_reg[1] + pr_reg[2];
        tu_s    = (U_W+1)'(u1_reg[0]) + (U_W+1)'(UNIT_ONE + 1);
        tv_s    = (U_W+1)'(u1_reg[1]) + (U_W+1)'(UNIT_ONE + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg <= dot_sum[DOT_W-1] ? '0 : dot_sum[DOT_W-2:0];
            u2_reg  <= u1_reg;
            a2_reg  <= a1_reg;
            tu2_reg <= tu_s[15:1];
            tv2_reg <= tv_s[15:1];
        end
    end

    // stage 3: ambient plus weighted diffuse
    logic [ACC_W-1:0] acc_reg [3];
    ucomp_t           u3_reg [3];
    logic [7:0]       a3_reg;
    logic [14:0]      tu3_reg, tv3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= (ACC_W'(ambient[8*i +: 8]) << (2 * IO_FRAC))
                              + ACC_W'(dot_reg) * ACC_W'(diffuse[8*i +: 8]);
            end
            u3_reg  <= u2_reg;
            a3_reg  <= a2_reg;
            tu3_reg <= tu2_reg;
            tv3_reg <= tv2_reg;
        end
    end

    // stage 4: round half up and saturate
    logic [ACC_W-1:0] rnd [3];
    logic [7:0]       col_next [3];
    logic [7:0]       col_reg [3];
    ucomp_t           u4_reg [3];
    logic [7:0]       a4_reg;
    logic [14:0]      tu4_reg, tv4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (acc_reg[i] + (ACC_W'(1) << (2 * IO_FRAC - 1))) >> (2 * IO_FRAC);
            col_next[i] = (rnd[i] > ACC_W'(255)) ? 8'hff : rnd[i][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_next;
            u4_reg  <= u3_reg;
            a4_reg  <= a3_reg;
            tu4_reg <= tu3_reg;
            tv4_reg <= tv3_reg;
        end
    end

    assign unit_out  = u4_reg;
    assign color     = col_reg;
    assign alpha_out = a4_reg;
    assign tex_u     = tu4_reg;
    assign tex_v     = tv4_reg;

endmodule

@@ src/vertex_normal_diffuse_lighting.sv @@
// throughput: one vertex per cycle; the whole pipeline advances together
// and holds while the output register is full and stalled
// reset: asynchronous active-low rst_n clears valid bits and loads the
// configuration defaults; the first transaction may follow right away
module vertex_normal_diffuse_lighting
    import vndl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [7:0]  normal_x,
    input  logic signed [7:0]  normal_y,
    input  logic signed [7:0]  normal_z,
    input  logic [7:0]         alpha,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] unit_x,
    output logic signed [15:0] unit_y,
    output logic signed [15:0] unit_z,
    output logic [7:0]         lit_red,
    output logic [7:0]         lit_green,
    output logic [7:0]         lit_blue,
    output logic [7:0]         lit_alpha,
    output logic [14:0]        tex_u,
    output logic [14:0]        tex_v,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int ALPHA_DLY = ROT_LAT + NORM_LAT;

    logic signed [15:0] rot_cos_reg, rot_sin_reg;
    logic [23:0]        ambient_reg, diffuse_reg, light_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_cos_reg <= 16'(UNIT_ONE);
            rot_sin_reg <= '0;
            ambient_reg <= '0;
            diffuse_reg <= 24'hffffff;
            light_reg   <= 24'h7f0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROT_COS: rot_cos_reg <= cfg_data[15:0];
                CFG_ROT_SIN: rot_sin_reg <= cfg_data[15:0];
                CFG_AMBIENT: ambient_reg <= cfg_data;
                CFG_DIFFUSE: diffuse_reg <= cfg_data;
                CFG_LIGHT:   light_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline control
    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    assign en        = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[PIPE_LAT-1];
    assign vld_next  = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic [7:0] alpha_reg [ALPHA_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= alpha;
            for (int i = 1; i < ALPHA_DLY; i++)
            begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    rcomp_t r [3];
    rcomp_t l [3];
    ucomp_t un [3];
    ucomp_t ln [3];
    ucomp_t unit_o [3];
    logic [7:0] color [3];

    vndl_rotate u_rotate
    (
        .clk     (clk),
        .en      (en),
        .nx      (normal_x),
        .ny      (normal_y),
        .nz      (normal_z),
        .rot_cos (rot_cos_reg),
        .rot_sin (rot_sin_reg),
        .light   (light_reg),
        .r       (r),
        .l       (l)
    );

    vndl_norm u_norm_n
    (
        .clk (clk),
        .en  (en),
        .r   (r),
        .u   (un)
    );

    vndl_norm u_norm_l
    (
        .clk (clk),
        .en  (en),
        .r   (l),
        .u   (ln)
    );

    vndl_shade u_shade
    (
        .clk       (clk),
        .en        (en),
        .un        (un),
        .ln        (ln),
        .alpha_in  (alpha_reg[ALPHA_DLY-1]),
        .ambient   (ambient_reg),
        .diffuse   (diffuse_reg),
        .unit_out  (unit_o),
        .color     (color),
        .alpha_out (lit_alpha),
        .tex_u     (tex_u),
        .tex_v     (tex_v)
    );

    assign unit_x    = unit_o[0];
    assign unit_y    = unit_o[1];
    assign unit_z    = unit_o[2];
    assign lit_red   = color[0];
    assign lit_green = color[1];
    assign lit_blue  = color[2];

endmodule

@@ src/vndl_checker.sv @@
// port-level checks for the vertex lighting pipeline, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module vndl_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] unit_x,
    input logic signed [15:0] unit_y,
    input logic signed [15:0] unit_z,
    input logic [7:0]         lit_red,
    input logic [14:0]        tex_u,
    input logic [14:0]        tex_v
);

    // input side only backs up when the output transaction is blocked
`VNDL_ASSERT(a_stall_cause, in_stall, out_valid && out_stall)
`VNDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(unit_x) && $stable(lit_red))
`VNDL_ASSERT(a_tex_u, out_valid, tex_u == 15'((17'(unit_x) + 17'sd16385) >>> 1))
`VNDL_ASSERT(a_tex_v, out_valid, tex_v == 15'((17'(unit_y) + 17'sd16385) >>> 1))
`VNDL_ASSERT(a_unit_range, out_valid, unit_z <= 16'sd16384 && unit_z >= -16'sd16384)

endmodule

bind vertex_normal_diffuse_lighting vndl_checker u_vndl_checker (.*);
